### src/tcbse_pkg.sv
// shared types, constants and saturation helpers for the tcb spline evaluator
`default_nettype none

package tcbse_pkg;

  localparam int MAX_KEYS = 16;
  localparam int KEY_AW   = $clog2(MAX_KEYS);
  localparam int CNT_W    = $clog2(MAX_KEYS + 1);
  localparam int KC_W     = 5;
  localparam int NW       = (CNT_W > KC_W) ? CNT_W : KC_W;

  // stream payload widths
  localparam int IN_DATA_W  = 192;
  localparam int OUT_DATA_W = 96;

  // datapath widths
  localparam int A_W   = 20;  // narrow multiplier operand
  localparam int B_W   = 48;  // wide multiplier operand
  localparam int P_W   = 68;  // product and accumulator
  localparam int F_W   = 17;  // tcb factor, 1 +- value in Q14
  localparam int TMP_W = 34;  // product of two factors
  localparam int K_W   = 20;  // tcb coefficient, Q14
  localparam int T_W   = 42;  // tangent, Q16.16
  localparam int H_W   = 46;  // saturated cubic term
  localparam int D_W   = 17;  // segment length
  localparam int V_W   = 19;  // fraction, signed Q2.16 within +-2.0
  localparam int DIV_N  = 33; // dividend bits
  localparam int DIV_DW = 16; // divisor bits
  localparam int DIV_CW = $clog2(DIV_N);
  localparam int V_LIM  = 1 << 17;

  localparam logic signed [F_W-1:0] ONE_Q14 = F_W'(16384);
  localparam logic signed [P_W-1:0] RND14   = P_W'(8192);
  localparam logic signed [P_W-1:0] RND29   = P_W'(1) << 28;
  localparam logic signed [P_W-1:0] TERM_LIM = P_W'(1) << 44;
  localparam logic signed [P_W-1:0] POS_LIM  = P_W'(32'h7fff_ffff);

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_EVAL  = 1'b1
  } req_e;

  typedef struct packed {
    logic signed [31:0] key_x;
    logic signed [31:0] key_y;
    logic signed [31:0] key_z;
    logic        [15:0] key_time;
    logic signed [15:0] tension;
    logic signed [15:0] continuity;
    logic signed [15:0] bias;
  } key_t;

  localparam int KEY_W = $bits(key_t);

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic signed [H_W-1:0] sat_term(input logic signed [P_W-1:0] x);
    logic signed [P_W-1:0] r;
    r = x;
    if (x > TERM_LIM) r = TERM_LIM;
    if (x < -TERM_LIM) r = -TERM_LIM;
    return H_W'(r);
  endfunction

  function automatic logic signed [31:0] sat_pos(input logic signed [P_W-1:0] x);
    logic signed [P_W-1:0] r;
    r = x;
    if (x > POS_LIM) r = POS_LIM;
    if (x < -POS_LIM) r = -POS_LIM;
    return 32'(r);
  endfunction

endpackage

`default_nettype wire

### src/tcb_spline_evaluator_top.sv
// top level: key table, search and cubic sequencer around one shared multiplier
// a key write gives its result in the cycle after the transfer. an evaluation runs
// search rounds of key fetches and a decision (up to log2(MAX_KEYS)+1 rounds), loads
// four keys, runs the bit-serial divider, then forms the coefficients and the three
// coordinates on the shared multiplier. one item at a time: the next transfer is taken
// once the state has gone from output back to idle after the result transfer.
// reset: key table valid bits cleared (all keys read as zero), key_count is 1.
`default_nettype none

module tcb_spline_evaluator_top
  import tcbse_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // tdata: key_index, key_x, key_y, key_z, key_time, tension, continuity, bias,
  // eval_time, zero pad
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  input  wire logic                  s_axis_tuser_i,   // req_type
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata_o,   // pos_x, pos_y, pos_z
  output logic                       m_axis_tuser_o,   // found
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  input  wire logic [KC_W-1:0]       cfg_data_i,       // key_count
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o
);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_FETCH  = 8'b0000_0010,
    ST_DECIDE = 8'b0000_0100,
    ST_DIVS   = 8'b0000_1000,
    ST_DIVW   = 8'b0001_0000,
    ST_COEF   = 8'b0010_0000,
    ST_CALC   = 8'b0100_0000,
    ST_OUT    = 8'b1000_0000
  } state_e;

  typedef enum logic [3:0] {
    OP_TO_A = 4'd0,
    OP_TO_B = 4'd1,
    OP_TI_A = 4'd2,
    OP_TI_B = 4'd3,
    OP_BI   = 4'd4,
    OP_CI   = 4'd5,
    OP_DI   = 4'd6,
    OP_H2   = 4'd7,
    OP_H1   = 4'd8,
    OP_H0   = 4'd9
  } calc_op_e;

  state_e state_q, state_d;

  // control
  logic [KC_W-1:0]   key_count_q;
  logic [MAX_KEYS-1:0] valid_q;
  logic              rv_q;
  logic [2:0]        rd_k_q;
  logic              load_q;
  logic              first_q;
  logic              ph_q;
  logic [2:0]        cf_q;
  calc_op_e          op_q;
  logic [1:0]        crd_q;
  logic              found_q;
  logic [KEY_AW-1:0] s_q, e_q;

  // payload
  key_t                    kq_q [4];
  logic [23:0]             et_q;
  logic signed [31:0]      res_q [3];
  logic signed [TMP_W-1:0] tmp_q;
  logic signed [K_W-1:0]   k_q [4];
  logic signed [P_W-1:0]   acc_q;
  logic signed [T_W-1:0]   to_q, ti_q;
  logic signed [H_W-1:0]   bi_q, ci_q, h_q;
  logic signed [D_W-1:0]   deltai_q;
  logic signed [V_W-1:0]   v_q;
  logic                    neg_q;

  // input fields
  key_t              in_key;
  logic [3:0]        in_index;
  logic [23:0]       in_et;
  logic              in_xfer;
  logic              out_xfer;

  assign in_index          = s_axis_tdata_i[3:0];
  assign in_key.key_x      = s_axis_tdata_i[35:4];
  assign in_key.key_y      = s_axis_tdata_i[67:36];
  assign in_key.key_z      = s_axis_tdata_i[99:68];
  assign in_key.key_time   = s_axis_tdata_i[115:100];
  assign in_key.tension    = s_axis_tdata_i[131:116];
  assign in_key.continuity = s_axis_tdata_i[147:132];
  assign in_key.bias       = s_axis_tdata_i[163:148];
  assign in_et             = s_axis_tdata_i[187:164];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = (state_q == ST_OUT);
  assign out_xfer        = m_axis_tvalid_o && m_axis_tready_i;
  assign m_axis_tdata_o  = {res_q[2], res_q[1], res_q[0]};
  assign m_axis_tuser_o  = found_q;
  assign cfg_ready_o     = 1'b1;

  // effective key count
  logic [NW-1:0]    kc_ext;
  logic [CNT_W-1:0] n_w;
  assign kc_ext = NW'(key_count_q);
  always_comb begin
    if (key_count_q == '0) n_w = CNT_W'(1);
    else if (kc_ext > NW'(MAX_KEYS)) n_w = CNT_W'(MAX_KEYS);
    else n_w = CNT_W'(kc_ext);
  end

  logic wr_ok;
  logic ram_we;
  assign wr_ok  = NW'(in_index) < NW'(n_w);
  assign ram_we = in_xfer && (req_e'(s_axis_tuser_i) == REQ_WRITE) && wr_ok;

  // key table
  logic [KEY_AW-1:0] raddr;
  logic [KEY_W-1:0]  rdata;
  key_t              rd_key;

  tcbse_ram #(
    .Width(KEY_W),
    .Depth(MAX_KEYS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(KEY_AW'(in_index)),
    .wdata_i(in_key),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // entries never written read as zero
  assign rd_key = rv_q ? key_t'(rdata) : '0;

  // fetch addresses: search reads s, s+1, mid, e; load reads prev, i, i+1, next
  logic [KEY_AW-1:0] m_w, pv_w, nx_w, s1_w;
  logic [CNT_W-1:0]  s2_w;
  assign s1_w = s_q + KEY_AW'(1);
  assign m_w  = KEY_AW'((CNT_W'(s_q) + CNT_W'(e_q)) >> 1);
  assign pv_w = (s_q == '0) ? KEY_AW'(n_w - CNT_W'(1)) : s_q - KEY_AW'(1);
  assign s2_w = CNT_W'(s_q) + CNT_W'(2);
  assign nx_w = (s2_w < n_w) ? KEY_AW'(s2_w) : '0;

  always_comb begin
    case (rd_k_q[1:0])
      2'd0:    raddr = load_q ? pv_w : s_q;
      2'd1:    raddr = load_q ? s_q : s1_w;
      2'd2:    raddr = load_q ? s1_w : m_w;
      default: raddr = load_q ? nx_w : e_q;
    endcase
  end

  // search decision
  logic [15:0] ct, t0, t1, t2, t3;
  logic        dec_miss, dec_hit, dec_lo, dec_hi;
  assign ct = et_q[23:8];
  assign t0 = kq_q[0].key_time;
  assign t1 = kq_q[1].key_time;
  assign t2 = kq_q[2].key_time;
  assign t3 = kq_q[3].key_time;

  always_comb begin
    dec_miss = 1'b0;
    dec_hit  = 1'b0;
    dec_lo   = 1'b0;
    dec_hi   = 1'b0;
    if (first_q && (ct > t3 || ct < t0)) dec_miss = 1'b1;
    else if (s_q >= e_q) dec_miss = 1'b1;
    else if (ct >= t0 && ct < t1) dec_hit = 1'b1;
    else if (s1_w == e_q) dec_hit = 1'b1;
    else if (ct >= t0 && ct < t2) dec_lo = 1'b1;
    else if (ct >= t2 && ct <= t3) dec_hi = 1'b1;
    else dec_miss = 1'b1;
  end

  // segment length and fraction numerator (keys i and i+1 sit in slots 1 and 2)
  logic signed [D_W-1:0] deltai_w, dabs_w;
  logic signed [24:0]    tq8_w;
  logic signed [32:0]    num_w;
  logic [DIV_N-1:0]      an_w;
  assign deltai_w = $signed({1'b0, kq_q[2].key_time}) - $signed({1'b0, kq_q[1].key_time});
  assign dabs_w   = deltai_w[D_W-1] ? -deltai_w : deltai_w;
  assign tq8_w    = $signed({1'b0, et_q}) - $signed({1'b0, kq_q[1].key_time, 8'b0});
  assign num_w    = {tq8_w, 8'b0};
  assign an_w     = num_w[32] ? -num_w : num_w;

  div_stat_t        div_st;
  logic [DIV_N-1:0] quot;
  logic             div_start;
  logic [17:0]      qc_w;
  logic signed [V_W-1:0] v_w;
  assign div_start = (state_q == ST_DIVS) && (deltai_w != '0);

  tcbse_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(an_w),
    .divisor_i (dabs_w[DIV_DW-1:0]),
    .stat_o    (div_st),
    .quot_o    (quot)
  );

  assign qc_w = (quot > DIV_N'(V_LIM)) ? 18'(V_LIM) : quot[17:0];
  assign v_w  = neg_q ? -$signed(V_W'(qc_w)) : $signed(V_W'(qc_w));

  // tcb factors for coefficient cf_q[2:1]: 0,1 outgoing of key i, 2,3 incoming of i+1
  key_t                  kc;
  logic signed [F_W-1:0] f_t, f_cm, f_cp, f_bm, f_bp, f2_w, f3_w;
  assign kc   = cf_q[2] ? kq_q[2] : kq_q[1];
  assign f_t  = ONE_Q14 - F_W'(kc.tension);
  assign f_cm = ONE_Q14 - F_W'(kc.continuity);
  assign f_cp = ONE_Q14 + F_W'(kc.continuity);
  assign f_bm = ONE_Q14 - F_W'(kc.bias);
  assign f_bp = ONE_Q14 + F_W'(kc.bias);

  always_comb begin
    case (cf_q[2:1])
      2'd0:    begin f2_w = f_cm; f3_w = f_bm; end
      2'd1:    begin f2_w = f_cp; f3_w = f_bp; end
      2'd2:    begin f2_w = f_cp; f3_w = f_bm; end
      default: begin f2_w = f_cm; f3_w = f_bp; end
    endcase
  end

  // coordinate of the four loaded keys
  logic signed [31:0] p_w [4];
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      case (crd_q)
        2'd0:    p_w[j] = kq_q[j].key_x;
        2'd1:    p_w[j] = kq_q[j].key_y;
        default: p_w[j] = kq_q[j].key_z;
      endcase
    end
  end

  logic signed [32:0] dn0, dl0, dn1, dp;
  logic signed [P_W-1:0] dpx;
  assign dn0 = 33'(p_w[2]) - 33'(p_w[1]);
  assign dl0 = 33'(p_w[1]) - 33'(p_w[0]);
  assign dn1 = 33'(p_w[3]) - 33'(p_w[2]);
  assign dp  = dn0;
  assign dpx = P_W'(dp);

  // shared multiplier operands, issued in the first half of each step
  logic signed [A_W-1:0] mul_a;
  logic signed [B_W-1:0] mul_b;
  logic signed [P_W-1:0] prod;
  logic                  mul_en;
  assign mul_en = ((state_q == ST_COEF) || (state_q == ST_CALC)) && !ph_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == ST_COEF) begin
      if (!cf_q[0]) begin
        mul_a = A_W'(f_t);
        mul_b = B_W'(f2_w);
      end else begin
        mul_a = A_W'(f3_w);
        mul_b = B_W'(tmp_q);
      end
    end else begin
      case (op_q)
        OP_TO_A: begin mul_a = k_q[0]; mul_b = B_W'(dn0); end
        OP_TO_B: begin mul_a = k_q[1]; mul_b = B_W'(dl0); end
        OP_TI_A: begin mul_a = k_q[2]; mul_b = B_W'(dn1); end
        OP_TI_B: begin mul_a = k_q[3]; mul_b = B_W'(dp); end
        OP_BI:   begin mul_a = A_W'(deltai_q); mul_b = B_W'(to_q); end
        OP_CI:   begin mul_a = A_W'(deltai_q); mul_b = (B_W'(to_q) <<< 1) + B_W'(ti_q); end
        OP_DI:   begin mul_a = A_W'(deltai_q); mul_b = B_W'(to_q) + B_W'(ti_q); end
        default: begin mul_a = A_W'(v_q); mul_b = B_W'(h_q); end
      endcase
    end
  end

  tcbse_mul u_mul (
    .clk_i(clk_i),
    .en_i (mul_en),
    .a_i  (mul_a),
    .b_i  (mul_b),
    .p_o  (prod)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (req_e'(s_axis_tuser_i) == REQ_WRITE || n_w < CNT_W'(2)) state_d = ST_OUT;
          else state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (rd_k_q == 3'd4) state_d = load_q ? ST_DIVS : ST_DECIDE;
      end
      ST_DECIDE: begin
        if (dec_miss) state_d = ST_OUT;
        else state_d = ST_FETCH;
      end
      ST_DIVS: begin
        state_d = (deltai_w != '0) ? ST_DIVW : ST_COEF;
      end
      ST_DIVW: begin
        if (div_st.done) state_d = ST_COEF;
      end
      ST_COEF: begin
        if (ph_q && cf_q == 3'd7) state_d = ST_CALC;
      end
      ST_CALC: begin
        if (ph_q && op_q == OP_H0 && crd_q == 2'd2) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_xfer) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      key_count_q <= KC_W'(1);
      valid_q     <= '0;
      rv_q        <= 1'b0;
      rd_k_q      <= '0;
      load_q      <= 1'b0;
      first_q     <= 1'b0;
      ph_q        <= 1'b0;
      cf_q        <= '0;
      op_q        <= OP_TO_A;
      crd_q       <= '0;
      found_q     <= 1'b0;
      s_q         <= '0;
      e_q         <= '0;
    end else begin
      state_q <= state_d;
      rv_q    <= valid_q[raddr];
      if (cfg_valid_i && cfg_ready_o) key_count_q <= cfg_data_i;
      if (ram_we) valid_q[KEY_AW'(in_index)] <= 1'b1;
      case (state_q)
        ST_IDLE: begin
          found_q <= 1'b0;
          s_q     <= '0;
          e_q     <= KEY_AW'(n_w - CNT_W'(1));
          first_q <= 1'b1;
          load_q  <= 1'b0;
          rd_k_q  <= '0;
        end
        ST_FETCH: begin
          rd_k_q <= rd_k_q + 3'd1;
        end
        ST_DECIDE: begin
          first_q <= 1'b0;
          rd_k_q  <= '0;
          if (dec_hit) load_q <= 1'b1;
          else if (dec_lo) e_q <= m_w;
          else if (dec_hi) s_q <= m_w;
        end
        ST_DIVS: begin
          ph_q <= 1'b0;
          cf_q <= '0;
          op_q <= OP_TO_A;
          crd_q <= '0;
        end
        ST_COEF: begin
          ph_q <= !ph_q;
          if (ph_q) cf_q <= cf_q + 3'd1;
        end
        ST_CALC: begin
          ph_q <= !ph_q;
          if (ph_q) begin
            if (op_q == OP_H0) begin
              op_q  <= OP_TO_A;
              crd_q <= crd_q + 2'd1;
              if (crd_q == 2'd2) found_q <= 1'b1;
            end else begin
              op_q <= calc_op_e'(op_q + 4'd1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        et_q <= in_et;
        for (int j = 0; j < 3; j++) res_q[j] <= '0;
      end
      ST_FETCH: begin
        if (rd_k_q != 3'd0) kq_q[2'(rd_k_q - 3'd1)] <= rd_key;
      end
      ST_DIVS: begin
        deltai_q <= deltai_w;
        neg_q    <= num_w[32] ^ deltai_w[D_W-1];
        v_q      <= '0;
      end
      ST_DIVW: begin
        if (div_st.done) v_q <= v_w;
      end
      ST_COEF: begin
        if (ph_q) begin
          if (!cf_q[0]) tmp_q <= TMP_W'(prod);
          else k_q[cf_q[2:1]] <= K_W'((prod + RND29) >>> 29);
        end
      end
      ST_CALC: begin
        if (ph_q) begin
          case (op_q)
            OP_TO_A: acc_q <= prod;
            OP_TO_B: to_q  <= T_W'((acc_q + prod + RND14) >>> 14);
            OP_TI_A: acc_q <= prod;
            OP_TI_B: ti_q  <= T_W'((acc_q + prod + RND14) >>> 14);
            OP_BI:   bi_q  <= sat_term(prod);
            OP_CI:   ci_q  <= sat_term((dpx <<< 1) + dpx - prod);
            OP_DI:   h_q   <= sat_term(prod - (dpx <<< 1));
            OP_H2:   h_q   <= sat_term(P_W'(ci_q) + (prod >>> 16));
            OP_H1:   h_q   <= sat_term(P_W'(bi_q) + (prod >>> 16));
            default: res_q[crd_q] <= sat_pos(P_W'(p_w[1]) + (prod >>> 16));
          endcase
        end
      end
      default: ;
    endcase
  end

  // one item in flight: the input side stays closed while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !s_axis_tready_o)
    else $error("input open while result pending");

  // a miss or a key write always reports a zero position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |-> (m_axis_tdata_o == '0))
    else $error("nonzero position without a segment");

  // a segment exists only with two keys or more
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (n_w >= CNT_W'(2)))
    else $error("segment found with a single key");

  // the divider runs only while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.busy |-> (state_q == ST_DIVW))
    else $error("divider busy outside its wait state");

endmodule

`default_nettype wire

### src/tcbse_ram.sv
// generic single-port-write ram with registered read
`default_nettype none

module tcbse_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### src/tcbse_mul.sv
// shared signed multiplier with registered product
`default_nettype none

module tcbse_mul
  import tcbse_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  en_i,
  input  wire logic signed [A_W-1:0] a_i,
  input  wire logic signed [B_W-1:0] b_i,
  output logic      signed [P_W-1:0] p_o
);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_o <= P_W'(a_i) * P_W'(b_i);
    end
  end

endmodule

`default_nettype wire

### src/tcbse_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none

module tcbse_div
  import tcbse_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DIV_N-1:0]  dividend_i,
  input  wire logic [DIV_DW-1:0] divisor_i,
  output div_stat_t              stat_o,
  output logic      [DIV_N-1:0]  quot_o
);

  logic              busy_q;
  logic              done_q;
  logic [DIV_CW-1:0] cnt_q;
  logic [DIV_N-1:0]  q_q;
  logic [DIV_DW-1:0] rem_q;
  logic [DIV_DW-1:0] dv_q;
  logic [DIV_DW:0]   trial;
  logic              ge;
  logic [DIV_DW:0]   diff;

  assign trial = {rem_q, q_q[DIV_N-1]};
  assign ge    = trial >= {1'b0, dv_q};
  assign diff  = trial - {1'b0, dv_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == DIV_CW'(DIV_N - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + DIV_CW'(1);
        if (cnt_q == DIV_CW'(DIV_N - 1)) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q   <= dividend_i;
      rem_q <= '0;
      dv_q  <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
      q_q   <= {q_q[DIV_N-2:0], ge};
    end
  end

  assign stat_o = '{busy: busy_q, done: done_q};
  assign quot_o = q_q;

endmodule

`default_nettype wire
